// ===== sv/dtt_pkg.sv =====
package dtt_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int MAX_FIRE        = 16;
  localparam int FIRE_W          = $clog2(MAX_FIRE + 1);

  typedef enum logic [2:0] {
    OP_CREATE     = 3'd0,
    OP_DELETE     = 3'd1,
    OP_TICK       = 3'd2,
    OP_FOREGROUND = 3'd3,
    OP_BACKGROUND = 3'd4
  } op_t;

  typedef enum logic {
    RK_FIRED   = 1'b0,
    RK_DROPPED = 1'b1
  } rkind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_APPLY,
    ST_DUE,
    ST_MIN,
    ST_EMIT,
    ST_RETIRE
  } state_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] timer_id;
    logic [31:0] duration_ms;
    logic [47:0] sched_time_ms;
    logic        repeats;
    logic [47:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] fired_id;
    logic        last_of_run;
  } evt_t;

  typedef struct packed {
    logic [31:0] key;
    logic [47:0] deadline;
    logic [31:0] period;
    logic        reload;
  } slot_t;

  // 48-bit time plus 32-bit duration, saturating at all ones
  function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

endpackage

// ===== sv/deadline_timer_table.sv =====
// Deadline timer table: a set of keyed timers, each with an absolute deadline,
// a period and a repeat flag.
// cmd channel (cmd_valid/cmd_ready/cmd): one item per operation - create,
// delete, tick, go foreground, go background. cmd_ready is high only while
// the sequencer is idle; one item is worked on at a time.
// evt channel (evt_valid/evt_ready/evt): fired timers and dropped creates, in
// order; last_of_run marks the final result of an item.
// Passes: every pass over the table goes through the
// single read port of the slot memory, one slot per cycle. Create and delete
// take one lookup pass, then the apply state, and an emit (then a retire if
// the id was stored) where a result is due. A tick takes one pass to mark the
// due entries, then one minimum-search pass, an emit and a retire per fired
// timer, up to 16 of them; a receiver stall holds the emit state.
// Reset: table empty (valid bits clear), foreground mode, no pending result.
// Stall: a result sits in the evt register until taken; the sequencer waits
// only when it has a further result and the register is still full.
module deadline_timer_table
  import dtt_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic evt_valid,
  input  logic evt_ready,
  output evt_t evt
);

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] NIDX = CW'(TIMER_SLOTS);

  // sequencer and scan pointer
  state_t            state, state_next;
  logic [CW-1:0]     idx, idx_next;
  logic              p_valid, p_valid_next;
  logic [IW-1:0]     p_idx, p_idx_next;

  // current item and table state
  cmd_t              cur, cur_next;
  logic              fg, fg_next;
  logic [TIMER_SLOTS-1:0] valid, valid_next;
  logic [TIMER_SLOTS-1:0] due, due_next;

  // tick bookkeeping
  logic [CW-1:0]     due_cnt, due_cnt_next;
  logic [FIRE_W-1:0] total, total_next;
  logic [FIRE_W-1:0] fired, fired_next;
  logic              tick_mode, tick_mode_next;

  // lookup / search results
  logic              found, found_next;
  logic              free_found, free_found_next;
  logic [IW-1:0]     free_idx, free_idx_next;
  logic              best_found, best_found_next;
  logic [IW-1:0]     tgt_idx, tgt_idx_next;
  slot_t             tgt, tgt_next;

  // results
  evt_t              pend, pend_next;
  logic              evt_valid_next;
  evt_t              evt_next;

  // slot memory
  slot_t             mem [TIMER_SLOTS];
  slot_t             rd;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  slot_t             mem_wdata;

  logic              scan_done;
  logic              hit;
  logic [CW-1:0]     cnt_inc;

  assign cmd_ready = (state == ST_IDLE);
  assign scan_done = (idx == NIDX);
  assign rd_addr   = scan_done ? '0 : idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd <= mem[rd_addr];
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    p_valid_next    = p_valid;
    p_idx_next      = p_idx;
    cur_next        = cur;
    fg_next         = fg;
    valid_next      = valid;
    due_next        = due;
    due_cnt_next    = due_cnt;
    total_next      = total;
    fired_next      = fired;
    tick_mode_next  = tick_mode;
    found_next      = found;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    best_found_next = best_found;
    tgt_idx_next    = tgt_idx;
    tgt_next        = tgt;
    pend_next       = pend;
    evt_valid_next  = evt_valid;
    evt_next        = evt;
    mem_we          = 1'b0;
    mem_waddr       = tgt_idx;
    mem_wdata       = tgt;
    hit             = 1'b0;
    cnt_inc         = due_cnt;

    // drop the held result once taken
    if (evt_valid && evt_ready) begin
      evt_valid_next = 1'b0;
    end

    // advance the scan pointer; the read for idx is registered and lands in the next cycle
    if (state inside {ST_LOOKUP, ST_DUE, ST_MIN}) begin
      if (!scan_done) begin
        idx_next     = idx + CW'(1);
        p_valid_next = 1'b1;
        p_idx_next   = idx[IW-1:0];
      end
    end

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cur_next        = cmd;
          found_next      = 1'b0;
          free_found_next = 1'b0;
          tick_mode_next  = 1'b0;
          idx_next        = '0;
          p_valid_next    = 1'b0;
          due_next        = '0;
          due_cnt_next    = '0;
          fired_next      = '0;
          case (cmd.operation)
            OP_CREATE, OP_DELETE: begin
              state_next = ST_LOOKUP;
            end
            OP_TICK: begin
              if (fg) begin
                tick_mode_next = 1'b1;
                state_next     = ST_DUE;
              end
            end
            OP_FOREGROUND: begin
              if (!fg) begin
                fg_next        = 1'b1;
                tick_mode_next = 1'b1;
                state_next     = ST_DUE;
              end
            end
            OP_BACKGROUND: begin
              fg_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_LOOKUP: begin
        if (p_valid) begin
          if (valid[p_idx] && rd.key == cur.timer_id) begin
            found_next   = 1'b1;
            tgt_idx_next = p_idx;
            tgt_next     = rd;
          end
          if (!valid[p_idx] && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = p_idx;
          end
        end
        if (scan_done) begin
          state_next = ST_APPLY;
        end
      end

      ST_APPLY: begin
        state_next = ST_IDLE;
        case (cur.operation)
          OP_CREATE: begin
            if (cur.duration_ms == '0 && !cur.repeats) begin
              // zero one-off timer fires at once; a stored twin is retired
              pend_next.result_kind = RK_FIRED;
              pend_next.fired_id    = cur.timer_id;
              pend_next.last_of_run = 1'b1;
              state_next            = ST_EMIT;
            end else if (found) begin
              state_next = ST_IDLE;
            end else if (!free_found) begin
              pend_next.result_kind = RK_DROPPED;
              pend_next.fired_id    = cur.timer_id;
              pend_next.last_of_run = 1'b1;
              state_next            = ST_EMIT;
            end else begin
              mem_we                  = 1'b1;
              mem_waddr               = free_idx;
              mem_wdata.key           = cur.timer_id;
              mem_wdata.deadline      = add_sat48(cur.sched_time_ms, cur.duration_ms);
              mem_wdata.period        = cur.duration_ms;
              mem_wdata.reload        = cur.repeats;
              valid_next[free_idx]    = 1'b1;
            end
          end
          OP_DELETE: begin
            if (found) begin
              valid_next[tgt_idx] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      ST_DUE: begin
        if (p_valid && valid[p_idx] && rd.deadline <= cur.now_ms) begin
          hit              = 1'b1;
          due_next[p_idx]  = 1'b1;
        end
        cnt_inc      = due_cnt + CW'(hit);
        due_cnt_next = cnt_inc;
        if (scan_done) begin
          if (32'(cnt_inc) >= 32'(MAX_FIRE)) begin
            total_next = FIRE_W'(MAX_FIRE);
          end else begin
            total_next = FIRE_W'(cnt_inc);
          end
          if (cnt_inc == '0) begin
            state_next = ST_IDLE;
          end else begin
            idx_next        = '0;
            p_valid_next    = 1'b0;
            best_found_next = 1'b0;
            state_next      = ST_MIN;
          end
        end
      end

      ST_MIN: begin
        // strict compare keeps the lower slot on ties
        if (p_valid && due[p_idx] && (!best_found || rd.deadline < tgt.deadline)) begin
          best_found_next = 1'b1;
          tgt_idx_next    = p_idx;
          tgt_next        = rd;
        end
        if (scan_done) begin
          pend_next.result_kind = RK_FIRED;
          pend_next.fired_id    = tgt_next.key;
          pend_next.last_of_run = ((fired + FIRE_W'(1)) == total);
          fired_next            = fired + FIRE_W'(1);
          state_next            = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!evt_valid || evt_ready) begin
          evt_valid_next = 1'b1;
          evt_next       = pend;
          state_next     = (tick_mode || found) ? ST_RETIRE : ST_IDLE;
        end
      end

      ST_RETIRE: begin
        // reload a repeating timer, remove a one-off
        if (tgt.reload) begin
          mem_we             = 1'b1;
          mem_waddr          = tgt_idx;
          mem_wdata          = tgt;
          mem_wdata.deadline = add_sat48(cur.now_ms, tgt.period);
        end else begin
          valid_next[tgt_idx] = 1'b0;
        end
        due_next[tgt_idx] = 1'b0;
        if (tick_mode && fired != total) begin
          idx_next        = '0;
          p_valid_next    = 1'b0;
          best_found_next = 1'b0;
          state_next      = ST_MIN;
        end else begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      p_valid   <= 1'b0;
      fg        <= 1'b1;
      valid     <= '0;
      due       <= '0;
      fired     <= '0;
      total     <= '0;
      evt_valid <= 1'b0;
    end else begin
      state     <= state_next;
      p_valid   <= p_valid_next;
      fg        <= fg_next;
      valid     <= valid_next;
      due       <= due_next;
      fired     <= fired_next;
      total     <= total_next;
      evt_valid <= evt_valid_next;
    end
    idx        <= idx_next;
    p_idx      <= p_idx_next;
    cur        <= cur_next;
    due_cnt    <= due_cnt_next;
    tick_mode  <= tick_mode_next;
    found      <= found_next;
    free_found <= free_found_next;
    free_idx   <= free_idx_next;
    best_found <= best_found_next;
    tgt_idx    <= tgt_idx_next;
    tgt        <= tgt_next;
    pend       <= pend_next;
    evt        <= evt_next;
  end

  // a minimum search always has at least one due entry left
  a_min_has_due: assert property (@(posedge clk) disable iff (rst)
    state == ST_MIN |-> due != '0)
    else $error("minimum search started with no due entry");

  // the entry retired by a tick was due
  a_retire_due: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RETIRE && tick_mode) |-> due[tgt_idx])
    else $error("tick retired an entry that was not due");

  // never fire more than the capped due count
  a_fire_cap: assert property (@(posedge clk) disable iff (rst)
    fired <= total)
    else $error("fired count passed the tick total");

  // a new entry goes into an empty slot
  a_free_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && mem_we) |-> !valid[free_idx])
    else $error("create overwrote a live slot");

endmodule

// ===== tb/deadline_timer_table_tb.sv =====
`timescale 1ns / 1ps
module deadline_timer_table_tb;
  import dtt_pkg::*;

  // Operation codes the block leaves undefined; it must ignore them
  localparam logic [2:0]  OP_SPARE_LO = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI = 3'd7;
  localparam logic [47:0] TIME_MAX    = '1;
  localparam int          POOL        = 20;   // ids shared by the shaped items
  localparam int          GAP_MAX     = 13;
  localparam int          RANDOM_ITEMS = 145;
  localparam int          SETTLE      = 400;  // idle time after the final drain

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  cmd_t        cmd       = '0;
  logic        evt_valid;
  logic        evt_ready = 1'b0;
  evt_t        evt;

  // Mirror of the timer table: works out the results of each accepted item
  // and holds them, oldest first, until the block delivers them.
  class fire_scoreboard;
    logic        live     [TIMER_SLOTS_DEF];
    logic [31:0] key      [TIMER_SLOTS_DEF];
    logic [47:0] deadline [TIMER_SLOTS_DEF];
    logic [31:0] period   [TIMER_SLOTS_DEF];
    logic        reload   [TIMER_SLOTS_DEF];
    logic        foreground;
    evt_t        awaited_fires[$];
    evt_t        run_fires[$];
    int unsigned mismatches;
    int unsigned fired_seen;
    int unsigned dropped_seen;
    int unsigned longest_run;
    int unsigned op_seen[8];

    function new();
      foreground = 1'b1;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function int awaited();
      return awaited_fires.size();
    endfunction

    function int unsigned spare_seen();
      int unsigned sum;
      sum = 0;
      for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) sum += op_seen[op];
      return sum;
    endfunction

    // base + step, held at the top of the 48-bit range
    function logic [47:0] later(input logic [47:0] base, input logic [31:0] step);
      logic [47:0] room;
      room = TIME_MAX - base;
      return (room < {16'd0, step}) ? TIME_MAX : base + {16'd0, step};
    endfunction

    function int slot_of(input logic [31:0] id);
      for (int i = 0; i < TIMER_SLOTS_DEF; i++)
        if (live[i] && key[i] == id) return i;
      return -1;
    endfunction

    function void push_fire(input rkind_t kind, input logic [31:0] id);
      evt_t e;
      e.result_kind = kind;
      e.fired_id    = id;
      e.last_of_run = 1'b0;
      run_fires = {run_fires, e};
    endfunction

    function void expire(input int s, input logic [47:0] now);
      if (reload[s]) deadline[s] = later(now, period[s]);
      else live[s] = 1'b0;
    endfunction

    function void fire_due(input logic [47:0] now);
      logic due [TIMER_SLOTS_DEF];
      int   best;
      if (!foreground) return;
      foreach (due[i]) due[i] = live[i] && deadline[i] <= now;
      for (int n = 0; n < MAX_FIRE; n++) begin
        best = -1;
        for (int i = 0; i < TIMER_SLOTS_DEF; i++)
          if (due[i] && (best < 0 || deadline[i] < deadline[best])) best = i;
        if (best < 0) break;
        due[best] = 1'b0;
        push_fire(RK_FIRED, key[best]);
        expire(best, now);
      end
    endfunction

    function void note_cmd(input cmd_t c);
      int s;
      int spare_slot;
      run_fires.delete();
      op_seen[c.operation]++;
      case (c.operation)
        OP_CREATE: begin
          if (c.duration_ms == '0 && !c.repeats) begin
            push_fire(RK_FIRED, c.timer_id);
            s = slot_of(c.timer_id);
            if (s >= 0) expire(s, c.now_ms);
          end else if (slot_of(c.timer_id) < 0) begin
            spare_slot = -1;
            for (int i = TIMER_SLOTS_DEF - 1; i >= 0; i--)
              if (!live[i]) spare_slot = i;
            if (spare_slot < 0) begin
              push_fire(RK_DROPPED, c.timer_id);
            end else begin
              live[spare_slot]     = 1'b1;
              key[spare_slot]      = c.timer_id;
              deadline[spare_slot] = later(c.sched_time_ms, c.duration_ms);
              period[spare_slot]   = c.duration_ms;
              reload[spare_slot]   = c.repeats;
            end
          end
        end
        OP_DELETE: begin
          s = slot_of(c.timer_id);
          if (s >= 0) live[s] = 1'b0;
        end
        OP_TICK: fire_due(c.now_ms);
        OP_FOREGROUND: begin
          if (!foreground) begin
            foreground = 1'b1;
            fire_due(c.now_ms);
          end
        end
        OP_BACKGROUND: foreground = 1'b0;
        default: ;
      endcase
      if (run_fires.size() > 0) begin
        run_fires[run_fires.size() - 1].last_of_run = 1'b1;
        if (run_fires.size() > longest_run) longest_run = run_fires.size();
      end
      awaited_fires = {awaited_fires, run_fires};
    endfunction

    task report(input string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task check_fire(input evt_t got);
      evt_t want;
      if (got.result_kind == RK_DROPPED) dropped_seen++;
      else fired_seen++;
      if (awaited_fires.size() == 0) begin
        report($sformatf("unexpected result kind %0d id %h last %0d",
                         got.result_kind, got.fired_id, got.last_of_run));
        return;
      end
      want = awaited_fires.pop_front();
      if (got.result_kind !== want.result_kind)
        report($sformatf("result_kind %0d, expected %0d (id %h)",
                         got.result_kind, want.result_kind, want.fired_id));
      if (got.fired_id !== want.fired_id)
        report($sformatf("fired_id %h, expected %h", got.fired_id, want.fired_id));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %0d, expected %0d (id %h)",
                         got.last_of_run, want.last_of_run, want.fired_id));
    endtask
  endclass

  fire_scoreboard board;
  logic [31:0]    pool [POOL];
  logic [47:0]    clock_ms;
  bit             steady = 1'b0;  // no gaps on either side while set
  int unsigned    ready_hold = 0;

  deadline_timer_table dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
  );

  always #6 clk = ~clk;

  // Result side: hold ready low for the drawn number of cycles, then keep it
  // high until the next item is taken. Only one update lands per falling edge.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      evt_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      evt_ready <= 1'b1;
    end
  end

  // Sample results on the rising edge and draw the stall before the next one
  always @(posedge clk) begin
    if (!rst && evt_valid && evt_ready) begin
      board.check_fire(evt);
      ready_hold <= steady ? 0 : $urandom_range(0, GAP_MAX);
    end
  end

  // Present one item after a drawn gap and hold it until accepted. A gap of
  // zero leaves valid high so that items follow back to back.
  task automatic send_cmd(input cmd_t c);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    board.note_cmd(c);
  endtask

  // Drop valid and wait until every predicted result has been delivered
  task automatic drain_expected();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (board.awaited() != 0) @(posedge clk);
  endtask

  function automatic cmd_t make_cmd(input logic [2:0] op, input logic [31:0] id,
                                    input logic [31:0] dur, input logic [47:0] sched,
                                    input logic rep, input logic [47:0] now);
    cmd_t c;
    c.operation     = op;
    c.timer_id      = id;
    c.duration_ms   = dur;
    c.sched_time_ms = sched;
    c.repeats       = rep;
    c.now_ms        = now;
    return c;
  endfunction

  // Mostly well-formed traffic around a moving clock: creates and deletes on
  // a small id pool so that duplicates, a full table and expiries all occur.
  // A few items are noise with fields drawn over their full width, the id and now only in half of them.
  function automatic cmd_t shaped_cmd();
    cmd_t        c;
    int unsigned pick;
    pick            = $urandom_range(0, 99);
    c.operation     = OP_TICK;
    c.timer_id      = pool[$urandom_range(0, POOL - 1)];
    c.duration_ms   = $urandom_range(1, 60);
    c.sched_time_ms = clock_ms;
    c.repeats       = ($urandom_range(0, 3) == 0);
    c.now_ms        = clock_ms;
    if (pick < 40) begin
      c.operation = OP_CREATE;
      if (pick < 5) begin
        // one-off with no duration: fires straight away
        c.duration_ms = '0;
        c.repeats     = 1'b0;
      end else if (pick < 8) begin
        c.duration_ms = $urandom;
      end
    end else if (pick < 55) begin
      c.operation = OP_DELETE;
    end else if (pick < 85) begin
      c.operation = OP_TICK;
    end else if (pick < 90) begin
      c.operation = OP_FOREGROUND;
    end else if (pick < 94) begin
      c.operation = OP_BACKGROUND;
    end else begin
      c.operation     = 3'($urandom_range(0, 7));
      c.duration_ms   = $urandom;
      c.sched_time_ms = {16'($urandom), 32'($urandom)};
      c.repeats       = 1'($urandom);
      if ($urandom_range(0, 1)) c.timer_id = $urandom;
      if ($urandom_range(0, 1)) c.now_ms = {16'($urandom), 32'($urandom)};
    end
    return c;
  endfunction

  task automatic directed_run();
    // Background: a tick would be held off, but a zero-duration one-off
    // still fires at once
    send_cmd(make_cmd(OP_BACKGROUND, '0, '0, '0, 1'b0, '0));
    send_cmd(make_cmd(OP_CREATE, '1, '0, '0, 1'b0, 48'd5));
    // Deadline and reload both saturate at the top of the time range
    send_cmd(make_cmd(OP_CREATE, pool[0], '1, TIME_MAX, 1'b1, '0));
    send_cmd(make_cmd(OP_FOREGROUND, '0, '0, '0, 1'b0, TIME_MAX));
    // Foreground while already in foreground does nothing
    send_cmd(make_cmd(OP_FOREGROUND, '0, '0, '0, 1'b0, TIME_MAX));
    // Delete of an id that is not stored
    send_cmd(make_cmd(OP_DELETE, '1, '0, '0, 1'b0, '0));
    // Undefined codes are ignored
    send_cmd(make_cmd(OP_SPARE_LO, $urandom, $urandom, '0, 1'b1, 48'd77));
    send_cmd(make_cmd(OP_SPARE_HI, '1, '1, TIME_MAX, 1'b1, TIME_MAX));
    // Fill the table; deadlines 1 to 4 give ties, one entry repeats
    for (int i = 1; i < TIMER_SLOTS_DEF; i++)
      send_cmd(make_cmd(OP_CREATE, pool[i], 32'(i % 4 + 1), '0, (i == 5), '0));
    // Full table: the create is dropped
    send_cmd(make_cmd(OP_CREATE, pool[16], 32'd3, '0, 1'b0, '0));
    // Existing id: entry kept as it is, no result even though the table is full
    send_cmd(make_cmd(OP_CREATE, pool[3], 32'd9, '0, 1'b1, '0));
    // Zero-duration one-off on the id of a repeating entry: fires, entry reloads
    send_cmd(make_cmd(OP_CREATE, pool[5], '0, '0, 1'b0, 48'd2));
    // Every slot due at once: sixteen results in deadline order
    send_cmd(make_cmd(OP_TICK, '0, '0, '0, 1'b0, TIME_MAX));
  endtask

  initial begin
    board    = new();
    clock_ms = 48'd1000;
    foreach (pool[i]) pool[i] = (i < 10) ? 32'(i) : $urandom;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_run();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // Switch between gapped traffic and stretches at full rate
      if (k % 25 == 0) steady = ($urandom_range(0, 3) == 0);
      // Halfway through, let the block run completely dry once
      if (k == RANDOM_ITEMS / 2) drain_expected();
      clock_ms = clock_ms + 48'($urandom_range(0, 40));
      send_cmd(shaped_cmd());
    end

    drain_expected();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d create, %0d delete, %0d tick, %0d foreground, %0d background,",
             board.op_seen[OP_CREATE], board.op_seen[OP_DELETE], board.op_seen[OP_TICK],
             board.op_seen[OP_FOREGROUND], board.op_seen[OP_BACKGROUND]);
    $display("%0d spare; %0d timers fired, %0d creates dropped, longest run %0d, %0d mismatches",
             board.spare_seen(), board.fired_seen, board.dropped_seen, board.longest_run,
             board.mismatches);
    if (board.mismatches == 0) begin
      $display("[deadline_timer_table] OK");
    end else begin
      $display("[deadline_timer_table] ERROR");
    end
    $finish;
  end

  // Give up long after the slowest legal run would have finished
  initial begin
    #20_000_000;
    $display("[deadline_timer_table] ERROR");
    $finish;
  end

endmodule
